[hw/rtl/rrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants of the recording ring directory.
// ----------------------------------------------------------------------------
package rrd_pkg;

    localparam int DEF_MAX_ENTRIES  = 16;
    localparam int DEF_SECTOR_BYTES = 4096;
    localparam int DEF_BLOCK_BYTES  = 256;

    localparam logic [31:0] RING_BYTES_RST = 32'd25157632;
    localparam logic [31:0] MIN_FREE_RST   = 32'd486654;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_MARK  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BUSY       = 3'd1;
    localparam logic [2:0] ST_LOW_SPACE  = 3'd2;
    localparam logic [2:0] ST_LIST_FULL  = 3'd3;
    localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;
    localparam logic [2:0] ST_AREA_FULL  = 3'd5;
    localparam logic [2:0] ST_NO_RING    = 3'd6;

    localparam logic REG_RING_BYTES = 1'b0;
    localparam logic REG_MIN_FREE   = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic        lang;
        logic [63:0] upload_mark;
    } rrd_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        flush_valid;
        logic [31:0] flush_offset;
        logic [12:0] flush_len;
        logic [1:0]  erase_sectors;
        logic [31:0] pending_bytes;
        logic [4:0]  pending_count;
        logic [4:0]  entry_count;
        logic        recording;
    } rrd_result_t;

    typedef struct packed {
        logic [63:0] start;
        logic [31:0] length;
        logic        done;
        logic        lang;
    } rrd_entry_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic close;
    } rrd_cell_ctl_t;

    typedef struct packed {
        logic above;
        logic done;
    } rrd_cell_flags_t;

endpackage

[hw/rtl/rrd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_cell
// One directory entry; shifts in its upper neighbor's entry on compaction.
// ----------------------------------------------------------------------------
module rrd_cell (
    input  logic                    clk,
    input  rrd_pkg::rrd_cell_ctl_t  ctl,
    input  rrd_pkg::rrd_entry_t     load_data,
    input  logic [31:0]             close_len,
    input  rrd_pkg::rrd_entry_t     nb_in,
    input  logic [63:0]             uploaded_head,
    output rrd_pkg::rrd_entry_t     q,
    output rrd_pkg::rrd_cell_flags_t flags
);
    import rrd_pkg::*;

    rrd_entry_t  ent_reg;
    logic [63:0] end_pos;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ent_reg <= load_data;
        end
        else if (ctl.close)
        begin
            ent_reg.length <= close_len;
            ent_reg.done   <= 1'b1;
        end
        else if (ctl.shift)
        begin
            ent_reg <= nb_in;
        end
    end

    assign end_pos     = ent_reg.start + {32'd0, ent_reg.length};
    assign flags.above = end_pos > uploaded_head;
    assign flags.done  = ent_reg.done;
    assign q           = ent_reg;

endmodule

[hw/rtl/rrd_mod_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_mod_unit
// Bit-serial restoring remainder of a 64-bit value by a 32-bit divisor.
// ----------------------------------------------------------------------------
module rrd_mod_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);
    logic [63:0] dq_reg, dq_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [31:0] dvs_reg;
    logic [32:0] trial;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[63]};
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            dq_next  = dividend;
            rem_next = 32'd0;
            cnt_next = 6'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            dq_next = {dq_reg[62:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
                rem_next = 32'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[31:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (go)
            dvs_reg <= divisor;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[hw/rtl/recording_ring_directory_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recording_ring_directory_top
// Bookkeeping for a byte ring of recordings in flash.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (cmd) is taken when start is high and busy is low. Exactly
//   one result word follows on result, marked by done for one cycle; the
//   receiver cannot stall it. The user must write registers ring_bytes (0x0)
//   and min_free_bytes (0x4) over the APB port only while idle; not enforced.
// Sequencing:
//   A page write runs through the bit-serial ring offset remainder unit
//   (one bit per cycle over 64 bits). A start on a full table first drops
//   the oldest entry; a mark while idle removes finished, uploaded entries
//   one at a time, as the entry chain shifts down one place per cycle.
//   One command is in work at a time.
// Reset:
//   Heads, counters and the table are empty; registers take their defaults.
// ----------------------------------------------------------------------------
module recording_ring_directory_top #(
    parameter int MAX_ENTRIES  = rrd_pkg::DEF_MAX_ENTRIES,
    parameter int SECTOR_BYTES = rrd_pkg::DEF_SECTOR_BYTES,
    parameter int BLOCK_BYTES  = rrd_pkg::DEF_BLOCK_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rrd_pkg::rrd_cmd_t    cmd,
    output logic                 done,
    output rrd_pkg::rrd_result_t result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rrd_pkg::*;

    localparam int UW     = $clog2(MAX_ENTRIES + 1);
    localparam int IW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FW     = $clog2(SECTOR_BYTES + BLOCK_BYTES + 1);
    localparam int SH     = $clog2(SECTOR_BYTES);
    localparam logic [63:0] SEC_M1 = 64'(SECTOR_BYTES - 1);
    localparam logic [63:0] SEC_MASK = ~SEC_M1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EXEC  = 10'b0000000010,
        S_FLUSH = 10'b0000000100,
        S_DIV   = 10'b0000001000,
        S_ERS   = 10'b0000010000,
        S_FLWR  = 10'b0000100000,
        S_FLEND = 10'b0001000000,
        S_RCHK  = 10'b0010000000,
        S_PURGE = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    typedef enum logic [2:0] {
        P_PAGE = 3'b001,
        P_FULL = 3'b010,
        P_STOP = 3'b100
    } post_t;

    state_t      state_reg, state_next;
    post_t       post_reg, post_next;
    rrd_cmd_t    cmd_reg;
    logic [31:0] ring_reg, minfree_reg;
    logic [63:0] dir_reg, dir_next, up_reg, up_next, live_reg, live_next;
    logic [63:0] ec_reg, ec_next, end_reg, end_next, eadd_reg, eadd_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [31:0] btr_reg, btr_next;
    logic        act_reg, act_next, ok_reg, ok_next;
    logic [UW-1:0] used_reg, used_next;
    logic [2:0]  st_reg, st_next;
    logic [1:0]  ers_reg, ers_next;
    logic        flv_reg, flv_next;
    logic [31:0] flo_reg, flo_next;
    logic [12:0] fll_reg, fll_next;
    logic        done_reg, done_next;
    rrd_result_t res_reg, res_next;

    rrd_entry_t      cell_q [MAX_ENTRIES];
    rrd_entry_t      cell_nb [MAX_ENTRIES];
    rrd_cell_flags_t cell_fl [MAX_ENTRIES];
    rrd_cell_ctl_t   cell_ctl [MAX_ENTRIES];
    rrd_entry_t      load_data;

    logic [MAX_ENTRIES-1:0] rm_vec, pc_vec;
    logic [IW-1:0] rm_idx;
    logic        rm_any;
    logic        drop_shift, purge_shift, append, close_now, div_go, div_done;
    logic [31:0] div_rem, pend32;
    logic [63:0] mark_c, fill64, diff;
    logic [UW-1:0] pc_cnt;

    // config port
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg    <= RING_BYTES_RST;
            minfree_reg <= MIN_FREE_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_RING_BYTES)
                ring_reg <= pwdata;
            else
                minfree_reg <= pwdata;
        end
    end
    assign prdata = (paddr[2] == REG_MIN_FREE) ? minfree_reg : ring_reg;

    // entry chain
    assign load_data = '{start: dir_reg, length: 32'd0, done: 1'b0, lang: cmd_reg.lang};

    generate
        for (genvar j = 0; j < MAX_ENTRIES; j++)
        begin : g_cell
            if (j == MAX_ENTRIES - 1)
            begin : g_last
                assign cell_nb[j] = '0;
            end
            else
            begin : g_mid
                assign cell_nb[j] = cell_q[j+1];
            end
            assign cell_ctl[j].shift = drop_shift || (purge_shift && (IW'(j) >= rm_idx));
            assign cell_ctl[j].load  = append && (UW'(j) == used_reg);
            assign cell_ctl[j].close = close_now && (used_reg != '0)
                                       && (UW'(j) == used_reg - UW'(1));
            assign rm_vec[j] = (UW'(j) < used_reg) && cell_fl[j].done && !cell_fl[j].above;
            assign pc_vec[j] = (UW'(j) < used_reg) && cell_fl[j].done && cell_fl[j].above;

            rrd_cell u_cell (
                .clk          (clk),
                .ctl          (cell_ctl[j]),
                .load_data    (load_data),
                .close_len    (btr_reg),
                .nb_in        (cell_nb[j]),
                .uploaded_head(up_reg),
                .q            (cell_q[j]),
                .flags        (cell_fl[j])
            );
        end
    endgenerate

    always_comb
    begin
        rm_idx = '0;
        rm_any = 1'b0;
        for (int j = MAX_ENTRIES - 1; j >= 0; j--)
        begin
            if (rm_vec[j])
            begin
                rm_idx = IW'(j);
                rm_any = 1'b1;
            end
        end
    end

    assign pc_cnt = UW'($countones(pc_vec));

    rrd_mod_unit u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (div_go),
        .dividend(live_reg),
        .divisor (ring_reg),
        .done    (div_done),
        .rem     (div_rem)
    );

    assign pend32 = (act_reg ? live_reg[31:0] : dir_reg[31:0]) - up_reg[31:0];
    assign fill64 = 64'(fill_reg);
    assign mark_c = (cmd_reg.upload_mark > dir_reg) ? dir_reg : cmd_reg.upload_mark;
    assign diff   = end_reg - ec_reg + SEC_M1;

    always_comb
    begin
        state_next = state_reg;
        post_next  = post_reg;
        dir_next   = dir_reg;
        up_next    = up_reg;
        live_next  = live_reg;
        ec_next    = ec_reg;
        end_next   = end_reg;
        eadd_next  = eadd_reg;
        fill_next  = fill_reg;
        btr_next   = btr_reg;
        act_next   = act_reg;
        ok_next    = ok_reg;
        used_next  = used_reg;
        st_next    = st_reg;
        ers_next   = ers_reg;
        flv_next   = flv_reg;
        flo_next   = flo_reg;
        fll_next   = fll_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        drop_shift  = 1'b0;
        purge_shift = 1'b0;
        append      = 1'b0;
        close_now   = 1'b0;
        div_go      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    flv_next   = 1'b0;
                    flo_next   = 32'd0;
                    fll_next   = 13'd0;
                    ers_next   = 2'd0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.kind)
                    KIND_START:
                    begin
                        state_next = S_FIN;
                        if (act_reg)
                            st_next = ST_BUSY;
                        else if (ring_reg == 32'd0)
                            st_next = ST_NO_RING;
                        else if (pend32 >= ring_reg || ring_reg - pend32 < minfree_reg)
                            st_next = ST_LOW_SPACE;
                        else if (used_reg >= UW'(MAX_ENTRIES))
                        begin
                            if (cell_fl[0].above)
                                st_next = ST_LIST_FULL;
                            else
                            begin
                                drop_shift = 1'b1;
                                used_next  = UW'(MAX_ENTRIES - 1);
                                state_next = S_EXEC;
                            end
                        end
                        else
                        begin
                            append    = 1'b1;
                            used_next = used_reg + UW'(1);
                            live_next = dir_reg;
                            btr_next  = 32'd0;
                            fill_next = '0;
                            ec_next   = (dir_reg + SEC_M1) & SEC_MASK;
                            act_next  = 1'b1;
                            st_next   = ST_OK;
                        end
                    end
                    KIND_BLOCK:
                    begin
                        if (!act_reg)
                        begin
                            st_next    = ST_NOT_ACTIVE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            fill_next = fill_reg + FW'(BLOCK_BYTES);
                            post_next = P_PAGE;
                            if (fill_reg + FW'(BLOCK_BYTES) >= FW'(SECTOR_BYTES))
                                state_next = S_FLUSH;
                            else
                                state_next = S_RCHK;
                        end
                    end
                    KIND_STOP:
                    begin
                        if (!act_reg)
                        begin
                            st_next    = ST_NOT_ACTIVE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            post_next  = P_STOP;
                            state_next = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        st_next    = ST_OK;
                        state_next = S_FIN;
                        if (mark_c > up_reg)
                        begin
                            up_next = mark_c;
                            if (!act_reg)
                                state_next = S_PURGE;
                        end
                    end
                endcase
            end
            S_FLUSH:
            begin
                if (fill_reg == '0)
                begin
                    ok_next    = 1'b1;
                    state_next = S_FLEND;
                end
                else if (ring_reg == 32'd0 || 32'(fill_reg) > ring_reg)
                begin
                    ok_next    = 1'b0;
                    state_next = S_FLEND;
                end
                else
                begin
                    end_next   = (live_reg + fill64 + SEC_M1) & SEC_MASK;
                    div_go     = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_ERS;
            end
            S_ERS:
            begin
                if (end_reg > ec_reg)
                begin
                    eadd_next = diff & SEC_MASK;
                    ers_next  = (diff[63:SH+2] != '0) ? 2'd3 : diff[SH+1:SH];
                end
                else
                begin
                    eadd_next = 64'd0;
                    ers_next  = 2'd0;
                end
                state_next = S_FLWR;
            end
            S_FLWR:
            begin
                flv_next   = 1'b1;
                flo_next   = div_rem;
                fll_next   = 13'(fill_reg);
                ec_next    = ec_reg + eadd_reg;
                live_next  = live_reg + fill64;
                btr_next   = btr_reg + 32'(fill_reg);
                fill_next  = '0;
                ok_next    = 1'b1;
                state_next = S_FLEND;
            end
            S_FLEND:
            begin
                state_next = S_FIN;
                if (post_reg == P_PAGE && ok_reg)
                    state_next = S_RCHK;
                else
                begin
                    close_now = 1'b1;
                    dir_next  = live_reg;
                    act_next  = 1'b0;
                    fill_next = '0;
                    if (!ok_reg)
                        st_next = ST_NO_RING;
                    else if (post_reg == P_FULL)
                        st_next = ST_AREA_FULL;
                    else
                        st_next = ST_OK;
                end
            end
            S_RCHK:
            begin
                if ({1'b0, pend32} + 33'(SECTOR_BYTES) > {1'b0, ring_reg})
                begin
                    post_next  = P_FULL;
                    state_next = S_FLUSH;
                end
                else
                begin
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
            end
            S_PURGE:
            begin
                if (rm_any)
                begin
                    purge_shift = 1'b1;
                    used_next   = used_reg - UW'(1);
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                res_next.status        = st_reg;
                res_next.flush_valid   = flv_reg;
                res_next.flush_offset  = flo_reg;
                res_next.flush_len     = fll_reg;
                res_next.erase_sectors = ers_reg;
                res_next.pending_bytes = pend32;
                res_next.pending_count = 5'(pc_cnt);
                res_next.entry_count   = 5'(used_reg);
                res_next.recording     = act_reg;
                done_next              = 1'b1;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            post_reg  <= P_PAGE;
            dir_reg   <= 64'd0;
            up_reg    <= 64'd0;
            live_reg  <= 64'd0;
            ec_reg    <= 64'd0;
            fill_reg  <= '0;
            btr_reg   <= 32'd0;
            act_reg   <= 1'b0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            post_reg  <= post_next;
            dir_reg   <= dir_next;
            up_reg    <= up_next;
            live_reg  <= live_next;
            ec_reg    <= ec_next;
            fill_reg  <= fill_next;
            btr_reg   <= btr_next;
            act_reg   <= act_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            cmd_reg <= cmd;
        end_reg  <= end_next;
        eadd_reg <= eadd_next;
        ok_reg   <= ok_next;
        st_reg   <= st_next;
        ers_reg  <= ers_next;
        flv_reg  <= flv_next;
        flo_reg  <= flo_next;
        fll_reg  <= fll_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
